// ===== rtl/agr_pkg.sv =====
// shared widths and the group size reset value for the alternate group reverser
`default_nettype none

package agr_pkg;

  localparam int VALUE_W = 32;
  localparam int GSIZE_W = 5;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd2;

endpackage

`default_nettype wire

// ===== rtl/alternate_group_reverser.sv =====
// alternate group reverser: reverses every other group of a value stream
`default_nettype none

// Values arrive one per transfer on the s_ side, and the final value of a
// sequence is marked by s_tlast. The sequence is cut into groups of
// group_size values (0 or 1 passes everything through; sizes above
// MAX_GROUP act as MAX_GROUP). Groups alternate, starting with a reversed
// one. A reversed group is written into a small synchronous memory, one
// value per cycle, and its completing value leaves at once; the values held
// before it are then read back newest first, each by a memory read and then
// the output register, during which no input is taken. Pass-through groups
// move one value per cycle. The end of a sequence flushes whatever is held,
// marks the last output with m_tlast and restarts with a reversed group.
// There is a single output register, and a result waiting in it for
// m_tready holds off input until it is taken, so these rates assume
// m_tready stays high.
module alternate_group_reverser #(
  parameter int MAX_GROUP = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire [agr_pkg::GSIZE_W-1:0]    cfg_wdata,   // group_size
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire [agr_pkg::VALUE_W-1:0]    s_tdata,     // value
  input  wire                           s_tlast,     // end_of_list
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [agr_pkg::VALUE_W-1:0]   m_tdata,     // out_value
  output logic                          m_tlast      // out_last
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int SW = (CW > agr_pkg::GSIZE_W) ? CW : agr_pkg::GSIZE_W;

  typedef enum logic [1:0] {S_IN, S_READ, S_WAIT} state_t;

  state_t                        state;
  logic [agr_pkg::GSIZE_W-1:0]   group_size;
  logic [CW-1:0]                 fill;
  logic [CW-1:0]                 pass_count;
  logic                          pass_phase;
  logic [AW-1:0]                 idx;
  logic                          flush_last;
  logic [agr_pkg::VALUE_W-1:0]   rd_data;
  logic [agr_pkg::VALUE_W-1:0]   mem [MAX_GROUP];

  logic [SW-1:0]                 gs_ext;
  logic [SW-1:0]                 k;
  logic [CW-1:0]                 fill_inc;
  logic [CW-1:0]                 pass_inc;
  logic                          in_xfer;
  logic                          out_free;
  logic                          flush_now;
  logic                          pass_done;
  logic                          wr_en;
  logic                          out_load;

  always_comb begin
    gs_ext    = SW'(group_size);
    k         = (gs_ext > SW'(MAX_GROUP)) ? SW'(MAX_GROUP) : gs_ext;
    fill_inc  = fill + 1'b1;
    pass_inc  = pass_count + 1'b1;
    out_free  = !m_tvalid || m_tready;
    s_tready  = (state == S_IN) && out_free;
    in_xfer   = s_tvalid && s_tready;
    flush_now = ((SW+1)'(fill_inc) >= (SW+1)'(k)) || s_tlast;
    pass_done = ((SW+1)'(pass_inc) >= (SW+1)'(k)) || s_tlast;
    wr_en     = in_xfer && !pass_phase && (fill < CW'(MAX_GROUP));
    // output register takes a new value this cycle
    out_load  = (in_xfer && (pass_phase || flush_now)) || ((state == S_WAIT) && out_free);
  end

  // group memory: written on reversed-group intake, read one entry per drain step
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[AW-1:0]] <= s_tdata;
    end
    if (state == S_READ) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IN;
      group_size <= agr_pkg::GSIZE_RESET;
      fill       <= '0;
      pass_count <= '0;
      pass_phase <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IN: begin
          if (in_xfer) begin
            if (!pass_phase) begin
              if (flush_now) begin
                // newest value of the reversed group leaves first
                m_tdata    <= s_tdata;
                m_tlast    <= s_tlast && (fill == '0);
                if (fill != '0) begin
                  idx        <= AW'(fill - 1'b1);
                  flush_last <= s_tlast;
                  state      <= S_READ;
                end
                fill       <= '0;
                pass_count <= '0;
                pass_phase <= !s_tlast && (k >= SW'(2));
              end else begin
                fill <= fill_inc;
              end
            end else begin
              m_tdata  <= s_tdata;
              m_tlast  <= s_tlast;
              if (pass_done) begin
                pass_phase <= 1'b0;
                pass_count <= '0;
              end else begin
                pass_count <= pass_inc;
              end
            end
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            m_tdata  <= rd_data;
            m_tlast  <= flush_last && (idx == '0);
            if (idx == '0) begin
              state <= S_IN;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/agr_checker.sv =====
// port-level checks for the alternate group reverser, bound to the top level
`default_nettype none

module agr_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire                          s_tlast,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [agr_pkg::VALUE_W-1:0]   m_tdata,
  input wire                          m_tlast
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // a stalled result keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("m_tdata or m_tlast changed while stalled");

  // input is only taken when the output register can receive
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("s_tready high with output register blocked");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid set right after reset");

  // a last input transfer always leaves a result offered
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("last input transfer produced no pending result");

endmodule

bind alternate_group_reverser agr_checker u_agr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
